// ----- sv/tcvp_pkg.sv -----
// tcvp_pkg: shared types and constants of the tilt cube vertex projector
// holds the state enum, register indexes, reset values and the cordic angle table
// no dependencies
package tcvp_pkg;

  localparam int unsigned CORDIC_STEPS_DEF  = 16;
  localparam int unsigned FRACTION_BITS_DEF = 13;

  // cordic start value, gain compensation in q2.30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  // register reset values
  localparam logic [7:0] CENTER_X_RST   = 8'd64;
  localparam logic [7:0] CENTER_Y_RST   = 8'd32;
  localparam logic [7:0] FOCAL_GAIN_RST = 8'd40;
  localparam logic [3:0] CAM_DIST_RST   = 4'd4;
  localparam logic [7:0] SCR_WIDTH_RST  = 8'd128;
  localparam logic [7:0] SCR_HEIGHT_RST = 8'd64;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_FOCAL_GAIN = 3'd2,
    REG_CAM_DIST   = 3'd3,
    REG_SCR_WIDTH  = 3'd4,
    REG_SCR_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_RY,
    ST_M_PX,
    ST_M_PY,
    ST_M_CX,
    ST_M_GX,
    ST_DIV_X,
    ST_M_CY,
    ST_M_GY,
    ST_DIV_Y,
    ST_OUT
  } state_e;

  // arctangent of 2^-i as binary angle, 2^32 per turn
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // corner signs, 1 means +1 and 0 means -1
  function automatic logic corner_x_pos(input logic [2:0] k);
    return k[0] ^ k[1];
  endfunction

  function automatic logic corner_y_pos(input logic [2:0] k);
    return k[1];
  endfunction

  function automatic logic corner_z_pos(input logic [2:0] k);
    return k[2];
  endfunction

endpackage

// ----- sv/tcvp_if.sv -----
// tcvp channel interfaces: tilt input, vertex output and register write
// valid/ready handshake, a beat moves when both are high
// no dependencies
interface tcvp_tilt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tilt_x;
  logic signed [15:0] tilt_y;
  modport source (output valid, tilt_x, tilt_y, input ready);
  modport sink   (input valid, tilt_x, tilt_y, output ready);
endinterface

interface tcvp_vertex_if;
  logic              valid;
  logic              ready;
  logic [2:0]        vertex_index;
  logic signed [9:0] screen_x;
  logic signed [9:0] screen_y;
  logic              on_screen;
  logic              last_vertex;
  modport source (output valid, vertex_index, screen_x, screen_y, on_screen, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_index, screen_x, screen_y, on_screen, last_vertex,
                  output ready);
endinterface

interface tcvp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/tilt_cube_vertex_projector_top.sv -----
// tilt_cube_vertex_projector_top: tilt pair to eight projected cube corners
// depends on tcvp_pkg and the channel interfaces in tcvp_if.sv

// One tilt beat yields eight vertex beats in corner order 0..7, the last one
// flagged. The block takes a tilt beat only when idle. Sine and cosine of roll
// and pitch come from one shared cordic stage, one angle after the other.
// Each corner then passes the rotation and the shared multiplier, then two
// restoring divisions, one quotient bit a cycle, and then the output register,
// where it waits until the vertex beat is taken. Registers may be written at
// any time the block is idle; the write channel is always ready.
module tilt_cube_vertex_projector_top #(
  parameter int unsigned CORDIC_STEPS  = tcvp_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned FRACTION_BITS = tcvp_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcvp_tilt_if.sink     tilt_i,
  tcvp_cfg_if.sink      cfg_i,
  tcvp_vertex_if.source vertex_o
);
  import tcvp_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int AW  = F + 6;          // depth and multiplier a operand
  localparam int BW  = F + 3;          // coordinates and multiplier b operand
  localparam int SW  = F + 2;          // sine and cosine
  localparam int PW  = AW + BW;        // product
  localparam int NW  = F + 15;         // numerator magnitude
  localparam int SHL = (F >= 15) ? F - 15 : 0;
  localparam int SHR = (F >= 15) ? 0 : 15 - F;
  localparam logic signed [39:0] HALF_Q = 40'sd1 <<< SHR >>> 1;
  localparam logic [5:0] CORDIC_END = 6'(CORDIC_STEPS);
  localparam logic [5:0] DIV_END    = 6'(NW - 1);

  state_e state_q, state_d;

  // configuration registers
  logic [7:0] cx_q, cy_q, gain_q, width_q, height_q;
  logic [3:0] dist_q;

  logic               ang_q;
  logic [5:0]         cnt_q;
  logic signed [15:0] tilt_y_q;
  logic signed [33:0] cx_r_q, cy_r_q, cz_r_q;
  logic signed [SW-1:0] sr_q, cr_q, sp_q, cp_q;
  logic [2:0]         k_q;
  logic signed [BW-1:0] ry_q, px_q, py_q;
  logic signed [AW-1:0] d_q;
  logic signed [PW-1:0] acc_q;
  logic [NW-1:0]      dvd_q;
  logic [AW-1:0]      rem_q;
  logic               neg_q;
  logic signed [9:0]  sx_q, sy_q;
  logic               vis_q;

  // register write port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= CENTER_X_RST;
      cy_q     <= CENTER_Y_RST;
      gain_q   <= FOCAL_GAIN_RST;
      dist_q   <= CAM_DIST_RST;
      width_q  <= SCR_WIDTH_RST;
      height_q <= SCR_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CENTER_X:   cx_q     <= cfg_i.data;
        REG_CENTER_Y:   cy_q     <= cfg_i.data;
        REG_FOCAL_GAIN: gain_q   <= cfg_i.data;
        REG_CAM_DIST:   dist_q   <= cfg_i.data[3:0];
        REG_SCR_WIDTH:  width_q  <= cfg_i.data;
        REG_SCR_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // cordic iteration
  logic [4:0]         ci;
  logic signed [33:0] c_dx, c_dy, c_at, cx_n, cy_n, cz_n;
  assign ci   = cnt_q[4:0];
  assign c_dx = cy_r_q >>> ci;
  assign c_dy = cx_r_q >>> ci;
  assign c_at = $signed({2'b00, atan_bam(ci)});
  always_comb begin
    if (!cz_r_q[33]) begin
      cx_n = cx_r_q - c_dx;
      cy_n = cy_r_q + c_dy;
      cz_n = cz_r_q - c_at;
    end else begin
      cx_n = cx_r_q + c_dx;
      cy_n = cy_r_q - c_dy;
      cz_n = cz_r_q + c_at;
    end
  end

  // q2.30 to q1.15 with rounding and saturation, then to q.F
  function automatic logic signed [SW-1:0] to_frac(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [15:0] t;
    logic signed [39:0] w;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767)       t = 16'sh7fff;
    else if (r < -34'sd32768) t = 16'sh8000;
    else                      t = r[15:0];
    w = ((40'(t)) <<< SHL) + HALF_Q;
    w = w >>> SHR;
    return w[SW-1:0];
  endfunction

  // rotated corner
  logic signed [BW-1:0] cp_e, sp_e, cpv, spv, ry_n, rz_n;
  logic signed [AW-1:0] d_n;
  assign cp_e = BW'(cp_q);
  assign sp_e = BW'(sp_q);
  always_comb begin
    cpv  = corner_y_pos(k_q) ? cp_e : -cp_e;
    spv  = corner_y_pos(k_q) ? sp_e : -sp_e;
    ry_n = cpv - (corner_z_pos(k_q) ? sp_e : -sp_e);
    rz_n = spv + (corner_z_pos(k_q) ? cp_e : -cp_e);
    d_n  = AW'(rz_n) + (AW'($signed({1'b0, dist_q})) <<< F);
    if (d_n < AW'(1)) d_n = AW'(1);
  end

  // shared multiplier
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] prod, prnd_w;
  logic signed [BW-1:0] prnd;
  always_comb begin
    ma = d_q;
    mb = BW'($signed({1'b0, gain_q}));
    unique case (state_q)
      ST_M_PX: begin ma = AW'(ry_q); mb = BW'(sr_q); end
      ST_M_PY: begin ma = AW'(ry_q); mb = BW'(cr_q); end
      ST_M_CX: begin ma = d_q; mb = BW'($signed({1'b0, cx_q})); end
      ST_M_CY: begin ma = d_q; mb = BW'($signed({1'b0, cy_q})); end
      ST_M_GX: ma = AW'(px_q);
      ST_M_GY: ma = AW'(py_q);
      default: ;
    endcase
  end
  assign prod   = ma * mb;
  assign prnd_w = (prod + (PW'(1) <<< (F - 1))) >>> F;
  assign prnd   = prnd_w[BW-1:0];

  // numerator and its magnitude
  logic signed [PW-1:0] num;
  logic [NW-1:0]        num_mag;
  assign num     = (state_q == ST_M_GY) ? acc_q - prod : acc_q + prod;
  assign num_mag = num[PW-1] ? NW'(-num) : NW'(num);

  // restoring divider step
  logic [AW-1:0] rem_sh;
  logic          ge;
  logic [NW-1:0] quo;
  logic signed [9:0] qsat;
  assign rem_sh = {rem_q[AW-2:0], dvd_q[NW-1]};
  assign ge     = rem_sh >= AW'(d_q);
  assign quo    = {dvd_q[NW-2:0], ge};
  always_comb begin
    if (quo > NW'(511)) qsat = neg_q ? -10'sd512 : 10'sd511;
    else                qsat = neg_q ? -$signed(quo[9:0]) : $signed(quo[9:0]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (tilt_i.valid) state_d = ST_CORDIC;
      ST_CORDIC: if (cnt_q == CORDIC_END && ang_q) state_d = ST_RY;
      ST_RY:     state_d = ST_M_PX;
      ST_M_PX:   state_d = ST_M_PY;
      ST_M_PY:   state_d = ST_M_CX;
      ST_M_CX:   state_d = ST_M_GX;
      ST_M_GX:   state_d = ST_DIV_X;
      ST_DIV_X:  if (cnt_q == DIV_END) state_d = ST_M_CY;
      ST_M_CY:   state_d = ST_M_GY;
      ST_M_GY:   state_d = ST_DIV_Y;
      ST_DIV_Y:  if (cnt_q == DIV_END) state_d = ST_OUT;
      ST_OUT:    if (vertex_o.ready) state_d = (k_q == 3'd7) ? ST_IDLE : ST_RY;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    tilt_i.ready          = (state_q == ST_IDLE);
    vertex_o.valid        = (state_q == ST_OUT);
    vertex_o.vertex_index = k_q;
    vertex_o.screen_x     = sx_q;
    vertex_o.screen_y     = sy_q;
    vertex_o.on_screen    = vis_q;
    vertex_o.last_vertex  = (k_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ang_q   <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          ang_q <= 1'b0;
          k_q   <= '0;
        end
        ST_CORDIC: begin
          if (cnt_q == CORDIC_END) begin
            cnt_q <= '0;
            ang_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_M_GX, ST_M_GY: cnt_q <= '0;
        ST_DIV_X, ST_DIV_Y: cnt_q <= cnt_q + 6'd1;
        ST_OUT: if (vertex_o.ready) k_q <= k_q + 3'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        tilt_y_q <= tilt_i.tilt_y;
        cx_r_q   <= CORDIC_K;
        cy_r_q   <= '0;
        cz_r_q   <= 34'(tilt_i.tilt_x) <<< 15;
      end
      ST_CORDIC: begin
        if (cnt_q == CORDIC_END) begin
          if (!ang_q) begin
            cr_q <= to_frac(cx_r_q);
            sr_q <= to_frac(cy_r_q);
          end else begin
            cp_q <= to_frac(cx_r_q);
            sp_q <= to_frac(cy_r_q);
          end
          cx_r_q <= CORDIC_K;
          cy_r_q <= '0;
          cz_r_q <= 34'(tilt_y_q) <<< 15;
        end else begin
          cx_r_q <= cx_n;
          cy_r_q <= cy_n;
          cz_r_q <= cz_n;
        end
      end
      ST_RY: begin
        ry_q <= ry_n;
        d_q  <= d_n;
      end
      ST_M_PX: px_q <= (corner_x_pos(k_q) ? BW'(cr_q) : -BW'(cr_q)) - prnd;
      ST_M_PY: py_q <= (corner_x_pos(k_q) ? BW'(sr_q) : -BW'(sr_q)) + prnd;
      ST_M_CX, ST_M_CY: acc_q <= prod;
      ST_M_GX, ST_M_GY: begin
        dvd_q <= num_mag;
        neg_q <= num[PW-1];
        rem_q <= '0;
      end
      ST_DIV_X, ST_DIV_Y: begin
        rem_q <= ge ? rem_sh - AW'(d_q) : rem_sh;
        dvd_q <= quo;
        if (cnt_q == DIV_END) begin
          if (state_q == ST_DIV_X) begin
            sx_q <= qsat;
          end else begin
            sy_q  <= qsat;
            vis_q <= !sx_q[9] && (sx_q < $signed({2'b00, width_q})) &&
                     !qsat[9] && (qsat < $signed({2'b00, height_q}));
          end
        end
      end
      default: ;
    endcase
  end

endmodule
